// ----- rtl/rti_pkg.sv -----
// shared types and constants of the ray-triangle intersection core
// no dependencies
package rti_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int QUOT_BITS  = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int EPS_W      = 16;
    localparam int DIST_W     = 32;
    localparam int BARY_W     = 17;
    localparam int LANES      = 3;

    localparam logic [EPS_W-1:0]  EPS_RESET = 16'd66;
    localparam logic [BARY_W-1:0] BARY_ONE  = 17'h10000;
    localparam logic [DIST_W-1:0] DIST_MAX  = 32'h7fff_ffff;
    localparam logic [DIST_W-1:0] DIST_MIN  = 32'h8000_0000;

    // divider lanes
    localparam int LANE_DIST = 0;
    localparam int LANE_U    = 1;
    localparam int LANE_V    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 2'd0,
        CFG_ORIGIN_Y    = 2'd1,
        CFG_ORIGIN_Z    = 2'd2,
        CFG_DET_EPSILON = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             hit;
        logic [LANES-1:0] ovf;
        logic [LANES-1:0] neg;
    } t_div_tag;

    typedef struct packed {
        logic                     hit;
        logic signed [DIST_W-1:0] ray_distance;
        logic [BARY_W-1:0]        bary_u;
        logic [BARY_W-1:0]        bary_v;
    } t_res;

endpackage

// ----- rtl/rti_if.sv -----
// valid/ready channel interfaces: ray beats in, intersection results out
// no dependencies
interface rti_ray_if #(parameter int COORD_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] dir_x, dir_y, dir_z;
    logic signed [COORD_WIDTH-1:0] vert0_x, vert0_y, vert0_z;
    logic signed [COORD_WIDTH-1:0] vert1_x, vert1_y, vert1_z;
    logic signed [COORD_WIDTH-1:0] vert2_x, vert2_y, vert2_z;

    modport source (
        output valid, dir_x, dir_y, dir_z, vert0_x, vert0_y, vert0_z,
               vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z,
        input  ready
    );
    modport sink (
        input  valid, dir_x, dir_y, dir_z, vert0_x, vert0_y, vert0_z,
               vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z,
        output ready
    );
endinterface

interface rti_hit_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] ray_distance;
    logic [16:0]        bary_u;
    logic [16:0]        bary_v;

    modport source (output valid, hit, ray_distance, bary_u, bary_v, input ready);
    modport sink   (input valid, hit, ray_distance, bary_u, bary_v, output ready);
endinterface

// ----- rtl/ray_triangle_intersection_core.sv -----
// ray-triangle intersection core, top level: config registers, bound tests,
// saturation and the output skid stage; uses rti_pkg, rti_if, rti_front, rti_dot, rti_div
//
//  channel  | dir | handshake          | beat content
//  ---------+-----+--------------------+---------------------------------------------
//  i_ray    | in  | valid/ready        | ray direction and three vertices, Q16.16
//  o_res    | out | valid/ready        | hit, ray_distance (Q16.16), bary_u, bary_v
//  i_cfg_*  | in  | write enable only  | origin x/y/z, det_epsilon
//
// one beat accepted per cycle while the skid entry is empty; from accept to result a beat passes
// 3 front stages, 3 dot stages, 1 bound test, 33 divider stages and the output register
// the divider is fully pipelined, one quotient bit per stage for all three lanes
// synchronous active-low reset clears all valid bits; config resets to origin 0, epsilon 66
// a stalled output parks one result in the skid stage; the pipeline holds while it is full
module ray_triangle_intersection_core import rti_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rti_ray_if.sink               i_ray,
    rti_hit_if.source             o_res
);
    localparam int W = COORD_WIDTH;
    localparam int E = W + 1;
    localparam int C = 2 * W + 3;
    localparam int D = 3 * W + 6;

    logic [CFG_DATA_W-1:0] r_org_x, r_org_y, r_org_z;
    logic [EPS_W-1:0]      r_eps;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_eps   <= EPS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:    r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y:    r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z:    r_org_z <= i_cfg_data;
                CFG_DET_EPSILON: r_eps   <= i_cfg_data[EPS_W-1:0];
            endcase
        end
    end

    // front end
    logic signed [W-1:0] dir [3], v0 [3], v1 [3], v2 [3], org [3];

    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;
    assign v0[0]  = i_ray.vert0_x;
    assign v0[1]  = i_ray.vert0_y;
    assign v0[2]  = i_ray.vert0_z;
    assign v1[0]  = i_ray.vert1_x;
    assign v1[1]  = i_ray.vert1_y;
    assign v1[2]  = i_ray.vert1_z;
    assign v2[0]  = i_ray.vert2_x;
    assign v2[1]  = i_ray.vert2_y;
    assign v2[2]  = i_ray.vert2_z;
    assign org[0] = W'($signed(r_org_x));
    assign org[1] = W'($signed(r_org_y));
    assign org[2] = W'($signed(r_org_z));

    assign i_ray.ready = en;

    logic                f_v;
    logic signed [E-1:0] f_dir [3], f_e1 [3], f_e2 [3], f_tv [3];
    logic signed [C-1:0] f_p [3], f_q [3];

    rti_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (i_ray.valid),
        .i_dir   (dir),
        .i_v0    (v0),
        .i_v1    (v1),
        .i_v2    (v2),
        .i_org   (org),
        .o_v     (f_v),
        .o_dir   (f_dir),
        .o_e1    (f_e1),
        .o_e2    (f_e2),
        .o_tv    (f_tv),
        .o_pvec  (f_p),
        .o_qvec  (f_q)
    );

    logic                d_v;
    logic signed [D-1:0] det, num_t, num_u, num_v;

    rti_dot #(.W(W)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (f_v),
        .i_dir   (f_dir),
        .i_e1    (f_e1),
        .i_e2    (f_e2),
        .i_tv    (f_tv),
        .i_pvec  (f_p),
        .i_qvec  (f_q),
        .o_v     (d_v),
        .o_det   (det),
        .o_num_t (num_t),
        .o_num_u (num_u),
        .o_num_v (num_v)
    );

    // bound tests against det
    function automatic logic [D-1:0] mag(input logic signed [D-1:0] x);
        return x[D-1] ? D'(-x) : D'(x);
    endfunction

    logic signed [D-1:0] eps_w;
    logic signed [D:0]   uv, det_x;
    logic                det_pos, det_neg, miss_pos, miss_neg, hit7;

    always_comb begin
        eps_w    = $signed(D'({r_eps, 32'h0}));
        uv       = (D+1)'(num_u) + (D+1)'(num_v);
        det_x    = (D+1)'(det);
        det_pos  = det > eps_w;
        det_neg  = det < -eps_w;
        miss_pos = num_u[D-1] || (num_u > det) || num_v[D-1] || (uv > det_x);
        miss_neg = (num_u > 0) || (num_u < det) || (num_v > 0) || (uv < det_x);
        priority if (det_pos) begin
            hit7 = !miss_pos;
        end else if (det_neg) begin
            hit7 = !miss_neg;
        end else begin
            hit7 = 1'b0;
        end
    end

    logic               r7_v, r7_hit;
    logic [LANES-1:0]   r7_neg;
    logic [D-1:0]       r7_den;
    logic [D-1:0]       r7_num [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_hit            <= hit7;
            r7_den            <= mag(det);
            r7_num[LANE_DIST] <= mag(num_t);
            r7_num[LANE_U]    <= mag(num_u);
            r7_num[LANE_V]    <= mag(num_v);
            r7_neg[LANE_DIST] <= num_t[D-1] ^ det[D-1];
            r7_neg[LANE_U]    <= num_u[D-1] ^ det[D-1];
            r7_neg[LANE_V]    <= num_v[D-1] ^ det[D-1];
        end
    end

    // overflow precheck and divider setup: quotient bits above QUOT_BITS mean saturation
    t_div_tag              tag8;
    logic [D-1:0]          rem8 [LANES];
    logic [QUOT_BITS-1:0]  low8 [LANES];
    logic [D+FRAC_BITS-1:0] nsh [LANES];

    always_comb begin
        tag8.hit = r7_hit;
        tag8.neg = r7_neg;
        for (int l = 0; l < LANES; l++) begin
            nsh[l]      = {r7_num[l], {FRAC_BITS{1'b0}}};
            tag8.ovf[l] = (D+FRAC_BITS)'(r7_num[l]) >= ((D+FRAC_BITS)'(r7_den) << FRAC_BITS);
            rem8[l]     = D'(nsh[l] >> QUOT_BITS);
            low8[l]     = nsh[l][QUOT_BITS-1:0];
        end
    end

    logic                 q_v;
    t_div_tag             q_tag;
    logic [QUOT_BITS-1:0] quo [LANES];

    rti_div #(.DW(D), .QB(QUOT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r7_v),
        .i_tag   (tag8),
        .i_den   (r7_den),
        .i_rem   (rem8),
        .i_low   (low8),
        .o_v     (q_v),
        .o_tag   (q_tag),
        .o_quo   (quo)
    );

    // saturation
    function automatic logic [BARY_W-1:0] bary_sat(input logic [QUOT_BITS-1:0] q,
                                                    input logic neg, input logic ovf);
        logic [BARY_W-1:0] r;
        priority if (neg && (q != '0)) begin
            r = '0;
        end else if (ovf || (q > QUOT_BITS'(BARY_ONE))) begin
            r = BARY_ONE;
        end else begin
            r = q[BARY_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] dist_sat(input logic [QUOT_BITS-1:0] q,
                                                    input logic neg, input logic ovf);
        logic [DIST_W-1:0] r;
        priority if (ovf) begin
            r = neg ? DIST_MIN : DIST_MAX;
        end else if (neg) begin
            r = (q > DIST_MIN) ? DIST_MIN : DIST_W'(~q + 1'b1);
        end else begin
            r = (q > DIST_MAX) ? DIST_MAX : DIST_W'(q);
        end
        return r;
    endfunction

    t_res res;

    always_comb begin
        res = '0;
        if (q_tag.hit) begin
            res.hit          = 1'b1;
            res.ray_distance = $signed(dist_sat(quo[LANE_DIST], q_tag.neg[LANE_DIST],
                                                q_tag.ovf[LANE_DIST]));
            res.bary_u       = bary_sat(quo[LANE_U], q_tag.neg[LANE_U], q_tag.ovf[LANE_U]);
            res.bary_v       = bary_sat(quo[LANE_V], q_tag.neg[LANE_V], q_tag.ovf[LANE_V]);
        end
    end

    // output register with one skid entry
    logic r_out_v, r_skid_v;
    t_res r_out, r_skid;
    logic load_out;

    assign en       = !r_skid_v;
    assign load_out = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load_out) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= q_v;
            end
        end else if (q_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (q_v && en) begin
            r_skid <= res;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.hit          = r_out.hit;
    assign o_res.ray_distance = r_out.ray_distance;
    assign o_res.bary_u       = r_out.bary_u;
    assign o_res.bary_v       = r_out.bary_v;

    // a miss beat carries all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |->
            (o_res.ray_distance == 0 && o_res.bary_u == 0 && o_res.bary_v == 0))
        else $error("miss result with nonzero fields");

    // truncated barycentrics never sum past one
    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((BARY_W+1)'(o_res.bary_u) + (BARY_W+1)'(o_res.bary_v)
                         <= (BARY_W+1)'(BARY_ONE)))
        else $error("barycentric sum above one");

    // the skid entry only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full with output register empty");

    // a parked result leaves the skid entry as soon as the output beat is taken
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_res.ready) |=> (!r_skid_v && r_out_v))
        else $error("skid entry did not drain");
endmodule

// ----- rtl/rti_front.sv -----
// front stages: edges, tvec, then the two cross products (products, differences)
// no package dependencies
module rti_front #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_v,
    input  logic signed [W-1:0]  i_dir [3],
    input  logic signed [W-1:0]  i_v0 [3],
    input  logic signed [W-1:0]  i_v1 [3],
    input  logic signed [W-1:0]  i_v2 [3],
    input  logic signed [W-1:0]  i_org [3],
    output logic                 o_v,
    output logic signed [W:0]    o_dir [3],
    output logic signed [W:0]    o_e1 [3],
    output logic signed [W:0]    o_e2 [3],
    output logic signed [W:0]    o_tv [3],
    output logic signed [2*W+2:0] o_pvec [3],
    output logic signed [2*W+2:0] o_qvec [3]
);
    localparam int E = W + 1;
    localparam int P = 2 * W + 2;
    localparam int C = 2 * W + 3;

    logic r1_v, r2_v, r3_v;
    logic signed [E-1:0] r1_dir [3], r1_e1 [3], r1_e2 [3], r1_tv [3];
    logic signed [E-1:0] r2_dir [3], r2_e1 [3], r2_e2 [3], r2_tv [3];
    logic signed [E-1:0] r3_dir [3], r3_e1 [3], r3_e2 [3], r3_tv [3];
    logic signed [P-1:0] r2_pa [3], r2_pb [3], r2_qa [3], r2_qb [3];
    logic signed [C-1:0] r3_p [3], r3_q [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_dir[i] <= E'(i_dir[i]);
                r1_e1[i]  <= E'(i_v1[i]) - E'(i_v0[i]);
                r1_e2[i]  <= E'(i_v2[i]) - E'(i_v0[i]);
                r1_tv[i]  <= E'(i_org[i]) - E'(i_v0[i]);
                r2_dir[i] <= r1_dir[i];
                r2_e1[i]  <= r1_e1[i];
                r2_e2[i]  <= r1_e2[i];
                r2_tv[i]  <= r1_tv[i];
                r3_dir[i] <= r2_dir[i];
                r3_e1[i]  <= r2_e1[i];
                r3_e2[i]  <= r2_e2[i];
                r3_tv[i]  <= r2_tv[i];
                r3_p[i]   <= C'(r2_pa[i]) - C'(r2_pb[i]);
                r3_q[i]   <= C'(r2_qa[i]) - C'(r2_qb[i]);
            end
            // pvec = dir x edge2
            r2_pa[0] <= r1_dir[1] * r1_e2[2];
            r2_pb[0] <= r1_dir[2] * r1_e2[1];
            r2_pa[1] <= r1_dir[2] * r1_e2[0];
            r2_pb[1] <= r1_dir[0] * r1_e2[2];
            r2_pa[2] <= r1_dir[0] * r1_e2[1];
            r2_pb[2] <= r1_dir[1] * r1_e2[0];
            // qvec = tvec x edge1
            r2_qa[0] <= r1_tv[1] * r1_e1[2];
            r2_qb[0] <= r1_tv[2] * r1_e1[1];
            r2_qa[1] <= r1_tv[2] * r1_e1[0];
            r2_qb[1] <= r1_tv[0] * r1_e1[2];
            r2_qa[2] <= r1_tv[0] * r1_e1[1];
            r2_qb[2] <= r1_tv[1] * r1_e1[0];
        end
    end

    assign o_v = r3_v;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_dir[i]  = r3_dir[i];
            o_e1[i]   = r3_e1[i];
            o_e2[i]   = r3_e2[i];
            o_tv[i]   = r3_tv[i];
            o_pvec[i] = r3_p[i];
            o_qvec[i] = r3_q[i];
        end
    end
endmodule

// ----- rtl/rti_dot.sv -----
// dot product stages: split partial products, term merge, three-term sum
// no package dependencies
module rti_dot #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_v,
    input  logic signed [W:0]     i_dir [3],
    input  logic signed [W:0]     i_e1 [3],
    input  logic signed [W:0]     i_e2 [3],
    input  logic signed [W:0]     i_tv [3],
    input  logic signed [2*W+2:0] i_pvec [3],
    input  logic signed [2*W+2:0] i_qvec [3],
    output logic                  o_v,
    output logic signed [3*W+5:0] o_det,
    output logic signed [3*W+5:0] o_num_t,
    output logic signed [3*W+5:0] o_num_u,
    output logic signed [3*W+5:0] o_num_v
);
    localparam int E = W + 1;
    localparam int C = 2 * W + 3;
    localparam int L = W + 1;       // low slice of the wide operand
    localparam int M = 2 * W + 3;   // partial product width
    localparam int D = 3 * W + 6;

    localparam int DOT_DET = 0;
    localparam int DOT_U   = 1;
    localparam int DOT_V   = 2;
    localparam int DOT_T   = 3;

    logic signed [E-1:0] a [4][3];
    logic signed [C-1:0] b [4][3];

    logic r4_v, r5_v, r6_v;
    logic signed [M-1:0] r4_lo [4][3], r4_hi [4][3];
    logic signed [D-1:0] r5_t [4][3];
    logic signed [D-1:0] r6_s [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[DOT_DET][i] = i_e1[i];
            b[DOT_DET][i] = i_pvec[i];
            a[DOT_U][i]   = i_tv[i];
            b[DOT_U][i]   = i_pvec[i];
            a[DOT_V][i]   = i_dir[i];
            b[DOT_V][i]   = i_qvec[i];
            a[DOT_T][i]   = i_e2[i];
            b[DOT_T][i]   = i_qvec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_lo[k][i] <= a[k][i] * $signed({1'b0, b[k][i][L-1:0]});
                    r4_hi[k][i] <= a[k][i] * $signed(b[k][i][C-1:L]);
                    r5_t[k][i]  <= (D'(r4_hi[k][i]) <<< L) + D'(r4_lo[k][i]);
                end
                r6_s[k] <= r5_t[k][0] + r5_t[k][1] + r5_t[k][2];
            end
        end
    end

    assign o_v     = r6_v;
    assign o_det   = r6_s[DOT_DET];
    assign o_num_u = r6_s[DOT_U];
    assign o_num_v = r6_s[DOT_V];
    assign o_num_t = r6_s[DOT_T];
endmodule

// ----- rtl/rti_div.sv -----
// pipelined restoring divider, one quotient bit per stage, three lanes share a divisor
// depends on rti_pkg
module rti_div import rti_pkg::*; #(
    parameter int DW = 102,
    parameter int QB = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  t_div_tag      i_tag,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem [LANES],
    input  logic [QB-1:0] i_low [LANES],
    output logic          o_v,
    output t_div_tag      o_tag,
    output logic [QB-1:0] o_quo [LANES]
);
    logic          r_v   [QB+1];
    t_div_tag      r_tag [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic [DW-1:0] r_rem [QB+1][LANES];
    logic [QB-1:0] r_low [QB+1][LANES];
    logic [QB-1:0] r_quo [QB+1][LANES];

    logic [DW-1:0] n_rem [QB+1][LANES];
    logic [QB-1:0] n_low [QB+1][LANES];
    logic [QB-1:0] n_quo [QB+1][LANES];
    logic [DW:0]   sh    [QB+1][LANES];
    logic [DW+1:0] diff  [QB+1][LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sh[0][l]    = '0;
            diff[0][l]  = '0;
            n_rem[0][l] = i_rem[l];
            n_low[0][l] = i_low[l];
            n_quo[0][l] = '0;
        end
        for (int s = 1; s <= QB; s++) begin
            for (int l = 0; l < LANES; l++) begin
                sh[s][l]    = {r_rem[s-1][l], r_low[s-1][l][QB-1]};
                diff[s][l]  = (DW+2)'(sh[s][l]) - (DW+2)'(r_den[s-1]);
                n_rem[s][l] = diff[s][l][DW+1] ? sh[s][l][DW-1:0] : diff[s][l][DW-1:0];
                n_low[s][l] = r_low[s-1][l] << 1;
                n_quo[s][l] = {r_quo[s-1][l][QB-2:0], ~diff[s][l][DW+1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_v;
            for (int s = 1; s <= QB; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_den[0] <= i_den;
            for (int s = 1; s <= QB; s++) begin
                r_tag[s] <= r_tag[s-1];
                r_den[s] <= r_den[s-1];
            end
            for (int s = 0; s <= QB; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_low[s][l] <= n_low[s][l];
                    r_quo[s][l] <= n_quo[s][l];
                end
            end
        end
    end

    assign o_v   = r_v[QB];
    assign o_tag = r_tag[QB];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[QB][l];
        end
    end
endmodule

// ----- bench/ray_triangle_intersection_core_test.sv -----
// self-checking bench for ray_triangle_intersection_core: random and directed ray beats,
// predicted hits compared field by field against the result channel
// depends on rti_pkg, rti_if and the core rtl
module ray_triangle_intersection_core_test import rti_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE = 65536;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [255:0] wide_t;
    typedef struct {
        logic signed [31:0] c [12];
    } ray_beat_t;

    class hit_scoreboard;
        t_res pending[$];
        int   errors;

        function void note_ray(t_res r);
            pending.push_back(r);
        endfunction

        function void check_hit(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result hit=%0d dist=%0d u=%0d v=%0d", $realtime,
                         got.hit, got.ray_distance, got.bary_u, got.bary_v);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d actual %0d", $realtime, want.hit, got.hit);
                errors++;
            end
            if (got.ray_distance !== want.ray_distance) begin
                $display("%0t: ray_distance expected %0d actual %0d", $realtime,
                         want.ray_distance, got.ray_distance);
                errors++;
            end
            if (got.bary_u !== want.bary_u) begin
                $display("%0t: bary_u expected %0d actual %0d", $realtime,
                         want.bary_u, got.bary_u);
                errors++;
            end
            if (got.bary_v !== want.bary_v) begin
                $display("%0t: bary_v expected %0d actual %0d", $realtime,
                         want.bary_v, got.bary_v);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rti_ray_if #(.COORD_WIDTH(32)) ray_ch ();
    rti_hit_if                     res_ch ();

    ray_triangle_intersection_core #(.COORD_WIDTH(32)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ray      (ray_ch.sink),
        .o_res      (res_ch.source)
    );

    hit_scoreboard      hits;
    logic signed [31:0] origin [3];
    logic [15:0]        det_eps;
    bit                 steady;
    int                 idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic logic [BARY_W-1:0] clamp_bary(wide_t x);
        if (x < 0) return '0;
        if (x > ONE) return BARY_ONE;
        return x[BARY_W-1:0];
    endfunction

    function automatic t_res predict_intersection(ray_beat_t b);
        wide_t d[3], v0[3], e1[3], e2[3], tv[3], pv[3], qv[3];
        wide_t det, eps_w, u, v, uv, dist_q;
        logic  pos;
        t_res  r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            d[i]  = b.c[i];
            v0[i] = b.c[3+i];
            e1[i] = wide_t'(b.c[6+i]) - v0[i];
            e2[i] = wide_t'(b.c[9+i]) - v0[i];
            tv[i] = wide_t'(origin[i]) - v0[i];
        end
        cross3(d, e2, pv);
        cross3(tv, e1, qv);
        det = dot3(e1, pv);
        eps_w = '0;
        eps_w[47:32] = det_eps;
        if (det > eps_w) pos = 1'b1;
        else if (det < -eps_w) pos = 1'b0;
        else return r;
        u  = dot3(tv, pv);
        v  = dot3(d, qv);
        uv = u + v;
        if (pos) begin
            if (u < 0 || u > det || v < 0 || uv > det) return r;
        end else begin
            if (u > 0 || u < det || v > 0 || uv < det) return r;
        end
        dist_q = (dot3(e2, qv) * ONE) / det;
        r.hit = 1'b1;
        if (dist_q > wide_t'(64'sd2147483647)) r.ray_distance = DIST_MAX;
        else if (dist_q < -wide_t'(64'sd2147483648)) r.ray_distance = DIST_MIN;
        else r.ray_distance = dist_q[31:0];
        r.bary_u = clamp_bary((u * ONE) / det);
        r.bary_v = clamp_bary((v * ONE) / det);
        return r;
    endfunction

    function automatic ray_beat_t mk_ray(int dx, int dy, int dz, int ax, int ay, int az,
                                         int bx, int by, int bz, int cx, int cy, int cz);
        ray_beat_t b;
        b.c = '{dx, dy, dz, ax, ay, az, bx, by, bz, cx, cy, cz};
        return b;
    endfunction

    function automatic longint rnd_offset(int shift);
        return longint'($signed($urandom)) >>> (31 - shift);
    endfunction

    // mostly rays aimed at a point in the plane of a triangle near the origin
    function automatic ray_beat_t random_ray();
        ray_beat_t b;
        longint    v0[3], v1[3], v2[3], p, dv;
        int        a, w, s, sh;
        if ($urandom_range(0, 3) == 0) begin
            foreach (b.c[i]) b.c[i] = $urandom;
            return b;
        end
        s  = $urandom_range(2, 24);
        a  = $urandom_range(0, 300);
        w  = $urandom_range(0, 300);
        sh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        for (int i = 0; i < 3; i++) begin
            v0[i] = longint'(origin[i]) + rnd_offset(s);
            v1[i] = v0[i] + rnd_offset(s);
            v2[i] = v0[i] + rnd_offset(s);
            p  = v0[i] + ((v1[i] - v0[i]) * a + (v2[i] - v0[i]) * w) / 256;
            dv = (p - longint'(origin[i])) >>> sh;
            b.c[i]   = dv[31:0];
            b.c[3+i] = v0[i][31:0];
            b.c[6+i] = v1[i][31:0];
            b.c[9+i] = v2[i][31:0];
        end
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 3; i++) b.c[i] = -b.c[i];
        end
        return b;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_ray(ray_beat_t b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_ch.valid   <= 1'b1;
        ray_ch.dir_x   <= b.c[0];
        ray_ch.dir_y   <= b.c[1];
        ray_ch.dir_z   <= b.c[2];
        ray_ch.vert0_x <= b.c[3];
        ray_ch.vert0_y <= b.c[4];
        ray_ch.vert0_z <= b.c[5];
        ray_ch.vert1_x <= b.c[6];
        ray_ch.vert1_y <= b.c[7];
        ray_ch.vert1_z <= b.c[8];
        ray_ch.vert2_x <= b.c[9];
        ray_ch.vert2_y <= b.c[10];
        ray_ch.vert2_z <= b.c[11];
        do @(posedge i_clk); while (!ray_ch.ready);
        hits.note_ray(predict_intersection(b));
    endtask

    task automatic wait_drained();
        while (hits.pending.size() != 0) @(posedge i_clk);
    endtask

    // block must be idle before a register write
    task automatic write_config(logic signed [31:0] ox, logic signed [31:0] oy,
                                logic signed [31:0] oz, logic [15:0] eps);
        t_cfg_idx idx;
        ray_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= idx;
            unique case (idx)
                CFG_ORIGIN_X:    i_cfg_data <= ox;
                CFG_ORIGIN_Y:    i_cfg_data <= oy;
                CFG_ORIGIN_Z:    i_cfg_data <= oz;
                CFG_DET_EPSILON: i_cfg_data <= {16'd0, eps};
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        origin  = '{ox, oy, oz};
        det_eps = eps;
    endtask

    task automatic run_directed();
        send_ray(mk_ray(ONE/4, ONE/4, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(ONE/4, ONE/4, ONE, 0, 0, ONE, 0, ONE, ONE, ONE, 0, ONE));
        send_ray(mk_ray(ONE, 0, 0, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(ONE, ONE, ONE, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        send_ray(mk_ray(ONE, 0, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(0, 0, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(0, ONE, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(ONE/2, ONE/2, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(ONE, ONE, ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(-ONE/4, -ONE/4, -ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        // tiny direction: near-parallel threshold and distance saturation
        send_ray(mk_ray(0, 0, 1, 0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
        send_ray(mk_ray(0, 0, 1, -ONE*16, -ONE*16, ONE*64, ONE*256, -ONE*16, ONE*64,
                        -ONE*16, ONE*256, ONE*64));
        send_ray(mk_ray(0, 0, 3, 0, 0, -ONE*128, ONE*8, 0, -ONE*128, 0, ONE*8, -ONE*128));
        begin
            ray_beat_t b;
            foreach (b.c[i]) b.c[i] = 32'h7fff_ffff;
            send_ray(b);
            foreach (b.c[i]) b.c[i] = 32'h8000_0000;
            send_ray(b);
            foreach (b.c[i]) b.c[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            send_ray(b);
            foreach (b.c[i]) b.c[i] = (i % 3 == 0) ? 32'h8000_0000 : 32'h0000_0001;
            send_ray(b);
            foreach (b.c[i]) b.c[i] = (i < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
            send_ray(b);
        end
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) steady = ($urandom_range(0, 2) == 0);
            if (n == count / 2) begin
                ray_ch.valid <= 1'b0;
                wait_drained();
            end
            send_ray(random_ray());
        end
    endtask

    // result side: random stalls with steady stretches
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.hit          = res_ch.hit;
            got.ray_distance = res_ch.ray_distance;
            got.bary_u       = res_ch.bary_u;
            got.bary_v       = res_ch.bary_v;
            hits.check_hit(got);
        end
    end

    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        hits = new;
        idle_cycles = 0;
        steady = 1'b0;
        origin = '{0, 0, 0};
        det_eps = EPS_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ORIGIN_X;
        i_cfg_data = '0;
        ray_ch.valid = 1'b0;
        {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} = '0;
        {ray_ch.vert0_x, ray_ch.vert0_y, ray_ch.vert0_z} = '0;
        {ray_ch.vert1_x, ray_ch.vert1_y, ray_ch.vert1_z} = '0;
        {ray_ch.vert2_x, ray_ch.vert2_y, ray_ch.vert2_z} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(150);
        write_config(0, 0, 0, 16'd0);
        run_directed();
        run_random(150);
        write_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        run_random(150);
        write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0);
        run_random(150);
        for (int k = 0; k < 3; k++) begin
            write_config($signed($urandom) >>> $urandom_range(0, 12),
                         $signed($urandom) >>> $urandom_range(0, 12),
                         $signed($urandom) >>> $urandom_range(0, 12),
                         16'($urandom_range(0, 65535)));
            run_random(170);
        end

        ray_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hits.errors == 0 && hits.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
